### rtl/core/rfhs_pkg.sv
// Shared types and constants of the RGB fade and hold sequencer.
// No dependencies; imported by rgb_fade_hold_sequencer_unit.
package rfhs_pkg;

   localparam int TABLE_DEPTH   = 64;
   localparam int FRACTION_BITS = 7;
   localparam int LEVEL_W       = 8;
   localparam int TICK_W        = 8;
   localparam int ACC_W         = 16;
   localparam int CHANNELS      = 3;
   localparam int TBL_AW        = $clog2(TABLE_DEPTH);
   localparam int QUO_W         = LEVEL_W + FRACTION_BITS;
   localparam int DIV_CW        = $clog2(QUO_W);

   localparam logic [TICK_W-1:0]  END_MARK       = 8'd255;
   localparam logic [LEVEL_W-1:0] BLINK_STEP_RST = 8'd20;
   localparam logic [LEVEL_W-1:0] BLINK_WRAP_RST = 8'd100;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_NEXT  = 2'd1;
   localparam logic [1:0] REQ_BLINK = 2'd2;
   localparam logic [1:0] REQ_WRITE = 2'd3;

   localparam logic CSR_BLINK_STEP = 1'b0;
   localparam logic CSR_BLINK_WRAP = 1'b1;

   typedef struct packed {
      logic [TICK_W-1:0]                 fade;
      logic [TICK_W-1:0]                 hold;
      logic [CHANNELS-1:0][LEVEL_W-1:0]  lvl;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HOLD_LD,
      ST_ADV_CUR,
      ST_ADV_NXT,
      ST_LOAD,
      ST_FADE,
      ST_DIV,
      ST_SEARCH
   } st_type;

   function automatic logic [TBL_AW-1:0] next_idx(input logic [TBL_AW-1:0] idx);
      logic [TBL_AW-1:0] res;
      if (idx == TBL_AW'(TABLE_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + 1'b1;
      end
      return res;
   endfunction

endpackage

### rtl/core/rgb_fade_hold_sequencer_unit.sv
// RGB fade and hold sequencer: pattern table memory, fade accumulators, blink control.
// Depends on rfhs_pkg.
// Table write, blink step and plain ticks answer straight from idle; a tick ending a fade
// answers via ST_HOLD_LD; a tick ending a hold runs ADV_CUR, ADV_NXT, LOAD, FADE and DIV.
// A next-pattern request scans the table one entry per cycle on the single read
// port, then runs LOAD, FADE and DIV. One transaction at a time.
// Synchronous active-high reset resets all control and channel state; table not cleared.
module rgb_fade_hold_sequencer_unit
   import rfhs_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic [TBL_AW-1:0]   req_entry_addr,
   input  logic [TICK_W-1:0]   req_fade_ticks,
   input  logic [TICK_W-1:0]   req_hold_ticks,
   input  logic [LEVEL_W-1:0]  req_red_level,
   input  logic [LEVEL_W-1:0]  req_green_level,
   input  logic [LEVEL_W-1:0]  req_blue_level,
   output logic                rsp_valid,
   output logic [LEVEL_W-1:0]  rsp_red_duty,
   output logic [LEVEL_W-1:0]  rsp_green_duty,
   output logic [LEVEL_W-1:0]  rsp_blue_duty,
   output logic                rsp_outputs_on,
   output logic                rsp_in_hold,
   output logic [TBL_AW-1:0]   rsp_current_entry,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [LEVEL_W-1:0]  csr_wdata
);

   st_type              state_ff, state_in;
   entry_type           tbl_mem [TABLE_DEPTH];
   entry_type           rd_data_ff;
   entry_type           wr_entry;
   logic [TBL_AW-1:0]   rd_addr;
   logic                accept;

   logic [LEVEL_W-1:0]  blink_step_ff, blink_wrap_ff;
   logic [LEVEL_W-1:0]  blink_period_ff, blink_cnt_ff;
   logic                lights_ff;
   logic [TBL_AW-1:0]   play_idx_ff, loop_start_ff;
   logic                hold_stage_ff;
   logic [TICK_W-1:0]   tick_cnt_ff;
   logic [ACC_W-1:0]    acc_ff  [CHANNELS];
   logic [ACC_W-1:0]    inc_ff  [CHANNELS];
   logic [ACC_W-1:0]    acc_sum [CHANNELS];
   logic [LEVEL_W-1:0]  duty_ff [CHANNELS];
   logic [LEVEL_W-1:0]  from_ff [CHANNELS];
   logic                done_ff;

   logic [TBL_AW-1:0]   scan_ff, chk_cnt_ff, srch_start;
   logic                data_ok_ff, srch_hit, srch_end;

   logic [LEVEL_W-1:0]  divisor_ff;
   logic                div_zero_ff;
   logic [DIV_CW-1:0]   div_cnt_ff;
   logic                div_last;
   logic                neg_ff   [CHANNELS];
   logic [QUO_W-1:0]    quo_ff   [CHANNELS];
   logic [QUO_W-1:0]    quo_step [CHANNELS];
   logic [LEVEL_W-1:0]  rem_ff   [CHANNELS];
   logic [LEVEL_W-1:0]  rem_step [CHANNELS];
   logic [LEVEL_W:0]    diff     [CHANNELS];
   logic [LEVEL_W-1:0]  diff_mag [CHANNELS];
   logic [ACC_W-1:0]    quo_ext  [CHANNELS];

   logic [LEVEL_W-1:0]  blink_dec, blink_sum;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start & ~busy;

   assign rsp_valid         = done_ff;
   assign rsp_red_duty      = duty_ff[0];
   assign rsp_green_duty    = duty_ff[1];
   assign rsp_blue_duty     = duty_ff[2];
   assign rsp_outputs_on    = lights_ff;
   assign rsp_in_hold       = hold_stage_ff;
   assign rsp_current_entry = play_idx_ff;

   assign wr_entry.fade   = req_fade_ticks;
   assign wr_entry.hold   = req_hold_ticks;
   assign wr_entry.lvl[0] = req_red_level;
   assign wr_entry.lvl[1] = req_green_level;
   assign wr_entry.lvl[2] = req_blue_level;

   assign blink_dec = blink_cnt_ff - 1'b1;
   assign blink_sum = blink_period_ff + blink_step_ff;

   assign srch_hit   = data_ok_ff && (rd_data_ff.fade == END_MARK);
   assign srch_end   = srch_hit || (data_ok_ff && (chk_cnt_ff == TBL_AW'(TABLE_DEPTH - 1)));
   assign srch_start = (srch_hit && (rd_data_ff.hold != END_MARK)) ? scan_ff : '0;
   assign div_last   = (div_cnt_ff == DIV_CW'(QUO_W - 1));

   always_comb begin
      logic [LEVEL_W:0]   partial;
      logic [LEVEL_W+1:0] trial;
      for (int c = 0; c < CHANNELS; c++) begin
         acc_sum[c]  = acc_ff[c] + inc_ff[c];
         diff[c]     = {1'b0, rd_data_ff.lvl[c]} - {1'b0, from_ff[c]};
         diff_mag[c] = diff[c][LEVEL_W] ? LEVEL_W'(-diff[c]) : diff[c][LEVEL_W-1:0];
         partial     = {rem_ff[c], quo_ff[c][QUO_W-1]};
         trial       = {1'b0, partial} - {2'b00, divisor_ff};
         if (!trial[LEVEL_W+1]) begin
            rem_step[c] = trial[LEVEL_W-1:0];
            quo_step[c] = {quo_ff[c][QUO_W-2:0], 1'b1};
         end else begin
            rem_step[c] = partial[LEVEL_W-1:0];
            quo_step[c] = {quo_ff[c][QUO_W-2:0], 1'b0};
         end
         quo_ext[c] = ACC_W'(quo_step[c]);
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_type == REQ_TICK) && (tick_cnt_ff == '0)) begin
               state_in = hold_stage_ff ? ST_ADV_CUR : ST_HOLD_LD;
            end else if (accept && (req_type == REQ_NEXT)) begin
               state_in = ST_SEARCH;
            end
         end
         ST_HOLD_LD: state_in = ST_IDLE;
         ST_ADV_CUR: state_in = ST_ADV_NXT;
         ST_ADV_NXT: state_in = ST_LOAD;
         ST_LOAD:    state_in = ST_FADE;
         ST_FADE:    state_in = ST_DIV;
         ST_DIV:     state_in = div_last ? ST_IDLE : ST_DIV;
         ST_SEARCH:  state_in = srch_end ? ST_LOAD : ST_SEARCH;
         default:    state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         ST_ADV_CUR: rd_addr = next_idx(play_idx_ff);
         ST_SEARCH:  rd_addr = scan_ff;
         default:    rd_addr = play_idx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && (req_type == REQ_WRITE)) begin
         tbl_mem[req_entry_addr] <= wr_entry;
      end
      rd_data_ff <= tbl_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         done_ff         <= 1'b0;
         blink_step_ff   <= BLINK_STEP_RST;
         blink_wrap_ff   <= BLINK_WRAP_RST;
         blink_period_ff <= '0;
         blink_cnt_ff    <= '0;
         lights_ff       <= 1'b1;
         play_idx_ff     <= '0;
         loop_start_ff   <= '0;
         hold_stage_ff   <= 1'b0;
         tick_cnt_ff     <= '0;
         scan_ff         <= '0;
         chk_cnt_ff      <= '0;
         data_ok_ff      <= 1'b0;
         divisor_ff      <= '0;
         div_zero_ff     <= 1'b0;
         div_cnt_ff      <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            acc_ff[c]  <= '0;
            inc_ff[c]  <= '0;
            duty_ff[c] <= '0;
            from_ff[c] <= '0;
            neg_ff[c]  <= 1'b0;
            quo_ff[c]  <= '0;
            rem_ff[c]  <= '0;
         end
      end else begin
         state_ff <= state_in;
         done_ff  <= 1'b0;

         if (csr_we) begin
            unique case (csr_index)
               CSR_BLINK_STEP: blink_step_ff <= csr_wdata;
               CSR_BLINK_WRAP: blink_wrap_ff <= csr_wdata;
               default:        blink_step_ff <= blink_step_ff;
            endcase
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  unique case (req_type)
                     REQ_TICK: begin
                        if (blink_period_ff != '0) begin
                           if (blink_dec == '0) begin
                              blink_cnt_ff <= blink_period_ff;
                              lights_ff    <= ~lights_ff;
                           end else begin
                              blink_cnt_ff <= blink_dec;
                           end
                        end
                        if (tick_cnt_ff == '0) begin
                           hold_stage_ff <= 1'b1;
                        end else begin
                           tick_cnt_ff <= tick_cnt_ff - 1'b1;
                           done_ff     <= 1'b1;
                           if (!hold_stage_ff) begin
                              for (int c = 0; c < CHANNELS; c++) begin
                                 acc_ff[c]  <= acc_sum[c];
                                 duty_ff[c] <= acc_sum[c][FRACTION_BITS+LEVEL_W-1:FRACTION_BITS];
                              end
                           end
                        end
                     end
                     REQ_NEXT: begin
                        scan_ff    <= next_idx(loop_start_ff);
                        chk_cnt_ff <= '0;
                        data_ok_ff <= 1'b0;
                        for (int c = 0; c < CHANNELS; c++) begin
                           from_ff[c] <= '0;
                        end
                     end
                     REQ_BLINK: begin
                        done_ff <= 1'b1;
                        if (blink_sum == blink_wrap_ff) begin
                           blink_period_ff <= '0;
                           blink_cnt_ff    <= '0;
                           lights_ff       <= 1'b1;
                        end else begin
                           blink_period_ff <= blink_sum;
                           blink_cnt_ff    <= blink_sum;
                        end
                     end
                     REQ_WRITE: done_ff <= 1'b1;
                     default:   done_ff <= 1'b1;
                  endcase
               end
            end
            ST_HOLD_LD: begin
               tick_cnt_ff <= rd_data_ff.hold;
               done_ff     <= 1'b1;
            end
            ST_ADV_CUR: begin
               for (int c = 0; c < CHANNELS; c++) begin
                  from_ff[c] <= rd_data_ff.lvl[c];
               end
            end
            ST_ADV_NXT: begin
               play_idx_ff <= (rd_data_ff.fade == END_MARK) ? loop_start_ff
                                                            : next_idx(play_idx_ff);
            end
            ST_LOAD: begin
               div_cnt_ff <= '0;
            end
            ST_FADE: begin
               hold_stage_ff <= 1'b0;
               tick_cnt_ff   <= rd_data_ff.fade;
               divisor_ff    <= rd_data_ff.fade;
               div_zero_ff   <= (rd_data_ff.fade == '0);
               div_cnt_ff    <= '0;
               for (int c = 0; c < CHANNELS; c++) begin
                  neg_ff[c] <= diff[c][LEVEL_W];
                  rem_ff[c] <= '0;
                  quo_ff[c] <= {diff_mag[c], {FRACTION_BITS{1'b0}}};
               end
            end
            ST_DIV: begin
               div_cnt_ff <= div_cnt_ff + 1'b1;
               for (int c = 0; c < CHANNELS; c++) begin
                  quo_ff[c] <= quo_step[c];
                  rem_ff[c] <= rem_step[c];
               end
               if (div_last) begin
                  done_ff <= 1'b1;
                  for (int c = 0; c < CHANNELS; c++) begin
                     if (div_zero_ff) begin
                        inc_ff[c] <= '0;
                     end else begin
                        inc_ff[c] <= neg_ff[c] ? -quo_ext[c] : quo_ext[c];
                     end
                  end
               end
            end
            ST_SEARCH: begin
               scan_ff    <= next_idx(scan_ff);
               data_ok_ff <= 1'b1;
               if (data_ok_ff) begin
                  chk_cnt_ff <= chk_cnt_ff + 1'b1;
               end
               if (srch_end) begin
                  loop_start_ff <= srch_start;
                  play_idx_ff   <= srch_start;
                  for (int c = 0; c < CHANNELS; c++) begin
                     acc_ff[c] <= '0;
                  end
               end
            end
            default: done_ff <= 1'b0;
         endcase
      end
   end

   a_rsp_when_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == ST_IDLE))
      else $error("response strobe while a transaction is still in work");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy) |-> $past(start))
      else $error("sequencer left idle without an accepted transaction");

   a_load_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> ($past(state_ff) == ST_ADV_NXT || $past(state_ff) == ST_SEARCH))
      else $error("entry load without advance or pattern search");

   a_fade_after_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_last) |=> (!hold_stage_ff && rsp_valid))
      else $error("fade start did not clear hold stage and respond");

endmodule

### test/rgb_fade_hold_sequencer_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for rgb_fade_hold_sequencer_unit: a sequencer model predicts the duties,
// stage, entry and output enable after each request transaction and checks every response.
// Depends on rfhs_pkg and rgb_fade_hold_sequencer_unit.
module rgb_fade_hold_sequencer_unit_test;
   import rfhs_pkg::*;

   localparam int STALL_LIMIT = 2000;

   typedef struct {
      logic [1:0]         kind;
      logic [TBL_AW-1:0]  addr;
      logic [TICK_W-1:0]  fade;
      logic [TICK_W-1:0]  hold;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } led_request_t;

   typedef struct packed {
      logic [LEVEL_W-1:0] red_duty;
      logic [LEVEL_W-1:0] green_duty;
      logic [LEVEL_W-1:0] blue_duty;
      logic               outputs_on;
      logic               in_hold;
      logic [TBL_AW-1:0]  current_entry;
   } led_status_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_type = REQ_TICK;
   logic [TBL_AW-1:0]  req_entry_addr = '0;
   logic [TICK_W-1:0]  req_fade_ticks = '0;
   logic [TICK_W-1:0]  req_hold_ticks = '0;
   logic [LEVEL_W-1:0] req_red_level = '0;
   logic [LEVEL_W-1:0] req_green_level = '0;
   logic [LEVEL_W-1:0] req_blue_level = '0;
   logic               rsp_valid;
   logic [LEVEL_W-1:0] rsp_red_duty;
   logic [LEVEL_W-1:0] rsp_green_duty;
   logic [LEVEL_W-1:0] rsp_blue_duty;
   logic               rsp_outputs_on;
   logic               rsp_in_hold;
   logic [TBL_AW-1:0]  rsp_current_entry;
   logic               csr_we = 1'b0;
   logic               csr_index = CSR_BLINK_STEP;
   logic [LEVEL_W-1:0] csr_wdata = '0;

   // sequencer model state
   entry_type          led_table [TABLE_DEPTH];
   logic [TBL_AW-1:0]  seq_index = '0;
   logic [TBL_AW-1:0]  pattern_base = '0;
   logic               holding = 1'b0;
   logic [TICK_W-1:0]  countdown = '0;
   logic [ACC_W-1:0]   chan_acc [CHANNELS] = '{default: '0};
   logic [ACC_W-1:0]   chan_step [CHANNELS] = '{default: '0};
   logic [LEVEL_W-1:0] chan_duty [CHANNELS] = '{default: '0};
   logic [LEVEL_W-1:0] blink_len = '0;
   logic [LEVEL_W-1:0] blink_count = '0;
   logic               lamps_on = 1'b1;
   logic [LEVEL_W-1:0] cfg_blink_step = BLINK_STEP_RST;
   logic [LEVEL_W-1:0] cfg_blink_wrap = BLINK_WRAP_RST;

   led_request_t       request_backlog [$];
   led_status_t        pending_led_status [$];
   bit                 req_taken = 1'b0;
   int                 gap_percent = 26;
   int                 error_count = 0;
   int                 idle_cycles = 0;

   rgb_fade_hold_sequencer_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_entry_addr    (req_entry_addr),
      .req_fade_ticks    (req_fade_ticks),
      .req_hold_ticks    (req_hold_ticks),
      .req_red_level     (req_red_level),
      .req_green_level   (req_green_level),
      .req_blue_level    (req_blue_level),
      .rsp_valid         (rsp_valid),
      .rsp_red_duty      (rsp_red_duty),
      .rsp_green_duty    (rsp_green_duty),
      .rsp_blue_duty     (rsp_blue_duty),
      .rsp_outputs_on    (rsp_outputs_on),
      .rsp_in_hold       (rsp_in_hold),
      .rsp_current_entry (rsp_current_entry),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   function automatic void load_fade(input logic [CHANNELS-1:0][LEVEL_W-1:0] from_levels);
      int diff;
      int quot;
      holding   = 1'b0;
      countdown = led_table[seq_index].fade;
      for (int c = 0; c < CHANNELS; c++) begin
         diff = int'(led_table[seq_index].lvl[c]) - int'(from_levels[c]);
         quot = (countdown == 0) ? 0 : (diff * (1 << FRACTION_BITS)) / int'(countdown);
         chan_step[c] = quot[ACC_W-1:0];
      end
   endfunction

   function automatic led_status_t led_status_after(input led_request_t rq);
      logic [TBL_AW-1:0]                pos;
      logic                             found;
      logic [CHANNELS-1:0][LEVEL_W-1:0] prev_levels;
      led_status_t                      status;
      case (rq.kind)
         REQ_TICK: begin
            if (blink_len != 0) begin
               blink_count = blink_count - 1'b1;
               if (blink_count == 0) begin
                  blink_count = blink_len;
                  lamps_on    = ~lamps_on;
               end
            end
            if (!holding) begin
               if (countdown == 0) begin
                  holding   = 1'b1;
                  countdown = led_table[seq_index].hold;
               end else begin
                  countdown = countdown - 1'b1;
                  for (int c = 0; c < CHANNELS; c++) begin
                     chan_acc[c]  = chan_acc[c] + chan_step[c];
                     chan_duty[c] = chan_acc[c][FRACTION_BITS +: LEVEL_W];
                  end
               end
            end else if (countdown == 0) begin
               prev_levels = led_table[seq_index].lvl;
               seq_index   = seq_index + 1'b1;
               if (led_table[seq_index].fade == END_MARK) seq_index = pattern_base;
               load_fade(prev_levels);
            end else begin
               countdown = countdown - 1'b1;
            end
         end
         REQ_NEXT: begin
            pos   = pattern_base;
            found = 1'b0;
            for (int n = 0; n < TABLE_DEPTH; n++) begin
               if (!found) begin
                  pos   = pos + 1'b1;
                  found = (led_table[pos].fade == END_MARK);
               end
            end
            if (!found || led_table[pos].hold == END_MARK) pattern_base = '0;
            else pattern_base = pos + 1'b1;
            seq_index = pattern_base;
            load_fade('0);
            for (int c = 0; c < CHANNELS; c++) chan_acc[c] = '0;
         end
         REQ_BLINK: begin
            blink_len = blink_len + cfg_blink_step;
            if (blink_len == cfg_blink_wrap) begin
               blink_len = '0;
               lamps_on  = 1'b1;
            end
            blink_count = blink_len;
         end
         REQ_WRITE: begin
            led_table[rq.addr].fade = rq.fade;
            led_table[rq.addr].hold = rq.hold;
            led_table[rq.addr].lvl  = {rq.blue, rq.green, rq.red};
         end
      endcase
      status.red_duty      = chan_duty[0];
      status.green_duty    = chan_duty[1];
      status.blue_duty     = chan_duty[2];
      status.outputs_on    = lamps_on;
      status.in_hold       = holding;
      status.current_entry = seq_index;
      return status;
   endfunction

   function automatic void queue_request(input logic [1:0] kind, input logic [TBL_AW-1:0] addr,
                                         input logic [TICK_W-1:0] fade,
                                         input logic [TICK_W-1:0] hold,
                                         input logic [LEVEL_W-1:0] red,
                                         input logic [LEVEL_W-1:0] green,
                                         input logic [LEVEL_W-1:0] blue);
      led_request_t rq;
      rq = '{kind, addr, fade, hold, red, green, blue};
      request_backlog.push_back(rq);
   endfunction

   function automatic void load_table(input bit with_marks);
      logic [TICK_W-1:0] fade;
      logic [TICK_W-1:0] hold;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         fade = TICK_W'($urandom_range(0, 4));
         hold = TICK_W'($urandom_range(0, 3));
         if (with_marks && i == TABLE_DEPTH - 1) begin
            fade = END_MARK;
            hold = END_MARK;
         end else if (with_marks && $urandom_range(0, 3) == 0) begin
            fade = END_MARK;
            hold = TICK_W'($urandom_range(0, 254));
         end
         queue_request(REQ_WRITE, TBL_AW'(i), fade, hold, LEVEL_W'($urandom),
                       LEVEL_W'($urandom), LEVEL_W'($urandom));
      end
   endfunction

   function automatic void queue_random(input int count);
      int                pick;
      logic [1:0]        kind;
      logic [TICK_W-1:0] fade;
      logic [TICK_W-1:0] hold;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 68) kind = REQ_TICK;
         else if (pick < 76) kind = REQ_NEXT;
         else if (pick < 83) kind = REQ_BLINK;
         else kind = REQ_WRITE;
         fade = TICK_W'($urandom);
         hold = TICK_W'($urandom);
         if (kind == REQ_WRITE) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) fade = TICK_W'($urandom_range(0, 6));
            else if (pick < 72) fade = END_MARK;
            pick = $urandom_range(0, 99);
            if (pick < 70) hold = TICK_W'($urandom_range(0, 5));
            else if (pick < 82) hold = END_MARK;
         end
         queue_request(kind, TBL_AW'($urandom), fade, hold, LEVEL_W'($urandom),
                       LEVEL_W'($urandom), LEVEL_W'($urandom));
      end
   endfunction

   task automatic write_csr(input logic idx, input logic [LEVEL_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_BLINK_STEP) cfg_blink_step = value;
      else cfg_blink_wrap = value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      #1;
   endtask

   task automatic wait_drained();
      while (request_backlog.size() != 0 || start || pending_led_status.size() != 0) begin
         @(posedge clock);
         #1;
      end
   endtask

   task automatic check_field(input string name, input logic [LEVEL_W-1:0] want,
                              input logic [LEVEL_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         error_count++;
      end
   endtask

   always @(negedge clock) begin : driver
      led_request_t next_req;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || req_taken) begin
         req_taken = 1'b0;
         if (request_backlog.size() != 0 && $urandom_range(0, 99) >= gap_percent) begin
            next_req = request_backlog.pop_front();
            start           <= 1'b1;
            req_type        <= next_req.kind;
            req_entry_addr  <= next_req.addr;
            req_fade_ticks  <= next_req.fade;
            req_hold_ticks  <= next_req.hold;
            req_red_level   <= next_req.red;
            req_green_level <= next_req.green;
            req_blue_level  <= next_req.blue;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      led_status_t  want;
      led_request_t seen;
      bit           moved;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         moved = 1'b0;
         if (rsp_valid) begin
            moved = 1'b1;
            if (pending_led_status.size() == 0) begin
               $error("response transaction with no request outstanding");
               error_count++;
            end else begin
               want = pending_led_status.pop_front();
               check_field("red_duty", want.red_duty, rsp_red_duty);
               check_field("green_duty", want.green_duty, rsp_green_duty);
               check_field("blue_duty", want.blue_duty, rsp_blue_duty);
               check_field("outputs_on", LEVEL_W'(want.outputs_on), LEVEL_W'(rsp_outputs_on));
               check_field("in_hold", LEVEL_W'(want.in_hold), LEVEL_W'(rsp_in_hold));
               check_field("current_entry", LEVEL_W'(want.current_entry),
                           LEVEL_W'(rsp_current_entry));
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            seen = '{req_type, req_entry_addr, req_fade_ticks, req_hold_ticks,
                     req_red_level, req_green_level, req_blue_level};
            pending_led_status.push_back(led_status_after(seen));
            req_taken = 1'b1;
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #1;

      load_table(1'b1);
      queue_request(REQ_WRITE, 0, 0, 0, 255, 0, 128);
      queue_request(REQ_WRITE, 1, 1, 1, 0, 255, 1);
      queue_request(REQ_WRITE, 2, END_MARK, 3, 0, 0, 0);
      queue_request(REQ_WRITE, 3, END_MARK, 2, 170, 85, 255);
      queue_request(REQ_WRITE, 4, 2, 0, 255, 255, 255);
      queue_request(REQ_WRITE, 5, END_MARK, END_MARK, 1, 2, 3);
      queue_request(REQ_WRITE, 63, 255, 255, 255, 255, 255);
      repeat (4) queue_request(REQ_TICK, 0, 0, 0, 0, 0, 0);
      queue_request(REQ_NEXT, 0, 0, 0, 0, 0, 0);
      repeat (2) queue_request(REQ_TICK, 0, 0, 0, 0, 0, 0);
      queue_request(REQ_BLINK, 0, 0, 0, 0, 0, 0);
      queue_request(REQ_TICK, 0, 0, 0, 0, 0, 0);
      repeat (4) queue_request(REQ_BLINK, 0, 0, 0, 0, 0, 0);
      queue_request(REQ_NEXT, 0, 0, 0, 0, 0, 0);
      queue_request(REQ_TICK, 0, 0, 0, 0, 0, 0);
      queue_request(REQ_WRITE, 0, 0, 0, 0, 0, 0);
      repeat (2) queue_request(REQ_TICK, 0, 0, 0, 0, 0, 0);
      queue_random(100);
      wait_drained();

      // back-to-back stretch with fast blinking
      write_csr(CSR_BLINK_STEP, 8'd1);
      write_csr(CSR_BLINK_WRAP, 8'd3);
      gap_percent = 0;
      queue_random(200);
      wait_drained();

      gap_percent = 26;
      write_csr(CSR_BLINK_STEP, 8'd255);
      write_csr(CSR_BLINK_WRAP, 8'd0);
      queue_random(200);
      wait_drained();

      // table without end marks, then restore a marked table
      write_csr(CSR_BLINK_STEP, 8'd0);
      write_csr(CSR_BLINK_WRAP, 8'd255);
      load_table(1'b0);
      queue_request(REQ_NEXT, 0, 0, 0, 0, 0, 0);
      repeat (30) queue_request(REQ_TICK, 0, 0, 0, 0, 0, 0);
      queue_request(REQ_NEXT, 0, 0, 0, 0, 0, 0);
      repeat (10) queue_request(REQ_TICK, 0, 0, 0, 0, 0, 0);
      load_table(1'b1);
      queue_random(200);
      wait_drained();

      write_csr(CSR_BLINK_STEP, 8'd7);
      write_csr(CSR_BLINK_WRAP, 8'd35);
      queue_random(200);
      wait_drained();

      write_csr(CSR_BLINK_STEP, LEVEL_W'($urandom_range(0, 255)));
      write_csr(CSR_BLINK_WRAP, LEVEL_W'($urandom_range(0, 255)));
      queue_random(50);
      wait_drained();

      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/rfhs_pkg.sv
rtl/core/rgb_fade_hold_sequencer_unit.sv
test/rgb_fade_hold_sequencer_unit_test.sv
